// ===== rtl/bpa_pkg.sv =====
// Bitmap page allocator: shared types and constants.
// No dependencies.
`timescale 1ns / 1ps

package bpa_pkg;

  localparam int CMD_W      = 2;
  localparam int CNT_W      = 15;
  localparam int ADDR_W     = 64;
  localparam int FRAME_W    = 52;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 52;
  localparam int WORD_BITS  = 64;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_IGNORED  = 2'd1,
    ST_NO_SPACE = 2'd2,
    ST_REJECTED = 2'd3
  } status_t;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE_FRAME = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_COUNT = 2'd1;

endpackage

// ===== rtl/bpa_cmd_if.sv =====
// Command channel of the bitmap page allocator.
// Depends on bpa_pkg.
`timescale 1ns / 1ps

interface bpa_cmd_if;
  logic                          valid;
  logic                          ready;
  logic [bpa_pkg::CMD_W-1:0]     command;
  logic [bpa_pkg::CNT_W-1:0]     page_count;
  logic [bpa_pkg::ADDR_W-1:0]    address;

  modport source (output valid, command, page_count, address, input ready);
  modport sink   (input valid, command, page_count, address, output ready);
endinterface

// ===== rtl/bpa_rsp_if.sv =====
// Response channel of the bitmap page allocator.
// Depends on bpa_pkg.
`timescale 1ns / 1ps

interface bpa_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [bpa_pkg::STATUS_W-1:0]  status;
  logic [bpa_pkg::ADDR_W-1:0]    run_address;
  logic [bpa_pkg::CNT_W-1:0]     pages_freed;
  logic [bpa_pkg::CNT_W-1:0]     pages_rejected;
  logic [bpa_pkg::CNT_W-1:0]     free_total;

  modport source (output valid, status, run_address, pages_freed, pages_rejected, free_total,
                  input ready);
  modport sink   (input valid, status, run_address, pages_freed, pages_rejected, free_total,
                  output ready);
endinterface

// ===== rtl/bitmap_page_allocator.sv =====
// Bitmap first-fit page allocator, top level. Depends on bpa_pkg, bpa_cmd_if,
// bpa_rsp_if, bpa_bitmap_ram, bpa_ctrl.
// Rate: one command at a time. Query or ignored command: straight to the result.
// Alloc: one read per bitmap word scanned (8 bits checked per cycle), then a
// read and a write-back per word marked. Free: page by page, plus a load (and
// write-back if changed) per new bitmap word. Reset: bitmap cleared, then free count
// rebuilt; a config write triggers the same rebuild. No command taken meanwhile.
`timescale 1ns / 1ps

module bitmap_page_allocator #(
  parameter int MAX_PAGES  = 16384,
  parameter int PAGE_BYTES = 4096
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [bpa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bpa_pkg::CFG_DATA_W-1:0]    cfg_data,
  bpa_cmd_if.sink                           in_ch,
  bpa_rsp_if.source                         out_ch
);
  import bpa_pkg::*;

  localparam int WORDS = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;

  logic                 mem_we;
  logic [WAW-1:0]       mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic                 mem_re;
  logic [WAW-1:0]       mem_raddr;
  logic [WORD_BITS-1:0] mem_rdata;

  bpa_ctrl #(
    .MAX_PAGES  (MAX_PAGES),
    .PAGE_BYTES (PAGE_BYTES),
    .WORDS      (WORDS),
    .WAW        (WAW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  bpa_bitmap_ram #(
    .DEPTH (WORDS),
    .AW    (WAW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

// ===== rtl/bpa_bitmap_ram.sv =====
// Bitmap store: one write port, one read port, registered read data.
// Depends on bpa_pkg.
`timescale 1ns / 1ps

module bpa_bitmap_ram #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic                            clk,
  input  logic                            we,
  input  logic [AW-1:0]                   waddr,
  input  logic [bpa_pkg::WORD_BITS-1:0]   wdata,
  input  logic                            re,
  input  logic [AW-1:0]                   raddr,
  output logic [bpa_pkg::WORD_BITS-1:0]   rdata
);
  import bpa_pkg::*;

  logic [WORD_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/bpa_ctrl.sv =====
// Allocator sequencer: config registers, clear/recount sweeps, first-fit scan,
// run marking, page-by-page free and result register. Depends on bpa_pkg,
// bpa_cmd_if, bpa_rsp_if; drives the bitmap store.
`timescale 1ns / 1ps

module bpa_ctrl #(
  parameter int MAX_PAGES  = 16384,
  parameter int PAGE_BYTES = 4096,
  parameter int WORDS      = 256,
  parameter int WAW        = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [bpa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bpa_pkg::CFG_DATA_W-1:0]    cfg_data,
  bpa_cmd_if.sink                           in_ch,
  bpa_rsp_if.source                         out_ch,
  output logic                              mem_we,
  output logic [WAW-1:0]                    mem_waddr,
  output logic [bpa_pkg::WORD_BITS-1:0]     mem_wdata,
  output logic                              mem_re,
  output logic [WAW-1:0]                    mem_raddr,
  input  logic [bpa_pkg::WORD_BITS-1:0]     mem_rdata
);
  import bpa_pkg::*;

  localparam int PW   = $clog2(MAX_PAGES + 1);
  localparam int NW   = ((PW > CNT_W) ? PW : CNT_W) + 1;
  localparam int PBW  = $clog2(PAGE_BYTES);
  localparam int IDXW = ADDR_W - PBW;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_RC_RD, S_RC_AC, S_AL_RD, S_AL_CH,
    S_MK_RD, S_MK_WR, S_FR_PG, S_FR_LD, S_DONE
  } state_t;

  state_t               state;
  logic [FRAME_W-1:0]   pool_frame;
  logic [CNT_W-1:0]     pool_cnt;
  logic                 rc_pend;
  logic [CNT_W-1:0]     tally;
  logic [CNT_W-1:0]     rc_acc;
  logic [WAW-1:0]       w;
  logic [2:0]           k;
  logic [CNT_W-1:0]     cnt;
  logic [NW-1:0]        run_len;
  logic [NW-1:0]        run_first;
  logic [ADDR_W-1:0]    pa;
  logic [CNT_W-1:0]     fi;
  logic [CNT_W-1:0]     freed;
  logic [CNT_W-1:0]     rejected;
  logic [WAW-1:0]       cw;
  logic                 cv;
  logic                 dirty;
  logic [WORD_BITS-1:0] cd;
  status_t              res_status;
  logic [ADDR_W-1:0]    res_run;

  logic                 out_valid;
  status_t              out_status;
  logic [ADDR_W-1:0]    out_run;
  logic [CNT_W-1:0]     out_freed;
  logic [CNT_W-1:0]     out_rej;
  logic [CNT_W-1:0]     out_total;

  logic [NW-1:0]        n_pages;
  logic [ADDR_W-1:0]    base_addr;
  logic                 in_acc;

  // first-fit chunk
  logic [NW-1:0]        c_len;
  logic [NW-1:0]        c_start;
  logic                 c_found;
  logic [NW-1:0]        c_page;
  logic [NW-1:0]        al_next_page;

  // run marking
  logic [NW-1:0]        mk_end;
  logic [5:0]           mk_lo;
  logic [5:0]           mk_hi;
  logic [WORD_BITS-1:0] mk_mask;

  // free
  logic                 fr_borrow;
  logic [ADDR_W-1:0]    fr_off;
  logic [IDXW-1:0]      fr_idx;
  logic                 fr_ok;
  logic [WAW-1:0]       fr_w;
  logic [5:0]           fr_b;
  logic                 fr_hit;
  logic                 fr_end;

  // recount
  logic [NW-1:0]        rc_base;
  logic [NW-1:0]        rc_rem;
  logic [WORD_BITS-1:0] rc_mask;
  logic [6:0]           rc_pop;

  assign n_pages   = (NW'(pool_cnt) > NW'(MAX_PAGES)) ? NW'(MAX_PAGES) : NW'(pool_cnt);
  assign base_addr = ADDR_W'({pool_frame, {PBW{1'b0}}});

  assign in_ch.ready = (state == S_IDLE) && !rc_pend && !cfg_we;
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign out_ch.valid          = out_valid;
  assign out_ch.status         = out_status;
  assign out_ch.run_address    = out_run;
  assign out_ch.pages_freed    = out_freed;
  assign out_ch.pages_rejected = out_rej;
  assign out_ch.free_total     = out_total;

  always_comb begin
    c_len   = run_len;
    c_start = run_first;
    c_found = 1'b0;
    c_page  = '0;
    for (int j = 0; j < 8; j++) begin
      c_page = NW'({w, k, 3'(j)});
      if (!c_found && (c_page < n_pages)) begin
        if (!mem_rdata[{k, 3'(j)}]) begin
          if (c_len == '0) begin
            c_start = c_page;
          end
          c_len = c_len + NW'(1);
          if (c_len >= NW'(cnt)) begin
            c_found = 1'b1;
          end
        end else begin
          c_len = '0;
        end
      end
    end
    al_next_page = NW'({w, k, 3'b000}) + NW'(8);
  end

  always_comb begin
    mk_end  = run_first + NW'(cnt) - NW'(1);
    mk_lo   = (w == run_first[6 +: WAW]) ? run_first[5:0] : 6'd0;
    mk_hi   = (w == mk_end[6 +: WAW]) ? mk_end[5:0] : 6'd63;
    mk_mask = ({WORD_BITS{1'b1}} << mk_lo) & ({WORD_BITS{1'b1}} >> (6'd63 - mk_hi));
  end

  always_comb begin
    {fr_borrow, fr_off} = {1'b0, pa} - {1'b0, base_addr};
    fr_idx = fr_off[ADDR_W-1:PBW];
    fr_ok  = (pa != '0) && !fr_borrow && (fr_off[PBW-1:0] == '0)
             && (fr_idx < IDXW'(n_pages));
    fr_w   = fr_idx[6 +: WAW];
    fr_b   = fr_idx[5:0];
    fr_hit = cv && (cw == fr_w);
    fr_end = (fi == cnt);
  end

  always_comb begin
    rc_base = NW'({w, 6'd0});
    rc_rem  = n_pages - rc_base;
    if (n_pages >= rc_base + NW'(64)) begin
      rc_mask = '1;
    end else if (n_pages > rc_base) begin
      rc_mask = ~({WORD_BITS{1'b1}} << rc_rem[5:0]);
    end else begin
      rc_mask = '0;
    end
    rc_pop = 7'($countones(~mem_rdata & rc_mask));
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = w;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = w;
    unique case (state)
      S_CLR: begin
        mem_we = 1'b1;
      end
      S_RC_RD, S_AL_RD, S_MK_RD: begin
        mem_re = 1'b1;
      end
      S_MK_WR: begin
        mem_we    = 1'b1;
        mem_wdata = mem_rdata | mk_mask;
      end
      S_FR_PG: begin
        mem_waddr = cw;
        mem_wdata = cd;
        mem_raddr = fr_w;
        if (fr_end) begin
          mem_we = cv && dirty;
        end else if (fr_ok && !fr_hit) begin
          mem_we = cv && dirty;
          mem_re = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLR;
      w          <= '0;
      rc_pend    <= 1'b1;
      pool_frame <= '0;
      pool_cnt   <= '0;
      tally      <= '0;
      cv         <= 1'b0;
      dirty      <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_BASE_FRAME: begin
            pool_frame <= cfg_data[FRAME_W-1:0];
            rc_pend    <= 1'b1;
          end
          CFG_PAGE_COUNT: begin
            pool_cnt <= cfg_data[CNT_W-1:0];
            rc_pend  <= 1'b1;
          end
          default: begin
          end
        endcase
      end
      if (out_ch.valid && out_ch.ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_CLR: begin
          if (w == WAW'(WORDS - 1)) begin
            w     <= '0;
            state <= S_IDLE;
          end else begin
            w <= w + WAW'(1);
          end
        end
        S_IDLE: begin
          if (rc_pend && !cfg_we) begin
            rc_pend <= 1'b0;
            rc_acc  <= '0;
            w       <= '0;
            state   <= S_RC_RD;
          end else if (in_acc) begin
            cnt        <= in_ch.page_count;
            pa         <= in_ch.address;
            fi         <= '0;
            freed      <= '0;
            rejected   <= '0;
            run_len    <= '0;
            run_first  <= '0;
            res_run    <= '0;
            w          <= '0;
            k          <= '0;
            cv         <= 1'b0;
            dirty      <= 1'b0;
            unique case (cmd_t'(in_ch.command))
              CMD_ALLOC: begin
                res_status <= ST_IGNORED;
                state      <= (in_ch.page_count != '0) ? S_AL_RD : S_DONE;
              end
              CMD_FREE: begin
                res_status <= ST_IGNORED;
                state      <= (in_ch.page_count != '0 && in_ch.address != '0) ? S_FR_PG
                                                                               : S_DONE;
              end
              CMD_QUERY: begin
                res_status <= ST_OK;
                state      <= S_DONE;
              end
              CMD_NONE: begin
                res_status <= ST_IGNORED;
                state      <= S_DONE;
              end
            endcase
          end
        end
        S_RC_RD: begin
          state <= S_RC_AC;
        end
        S_RC_AC: begin
          rc_acc <= rc_acc + CNT_W'(rc_pop);
          if (w == WAW'(WORDS - 1)) begin
            tally <= rc_acc + CNT_W'(rc_pop);
            state <= S_IDLE;
          end else begin
            w     <= w + WAW'(1);
            state <= S_RC_RD;
          end
        end
        S_AL_RD: begin
          k     <= '0;
          state <= S_AL_CH;
        end
        S_AL_CH: begin
          run_len   <= c_len;
          run_first <= c_start;
          if (c_found) begin
            w     <= c_start[6 +: WAW];
            state <= S_MK_RD;
          end else if (al_next_page >= n_pages) begin
            res_status <= ST_NO_SPACE;
            state      <= S_DONE;
          end else begin
            k <= k + 3'd1;
            if (k == 3'd7) begin
              w     <= w + WAW'(1);
              state <= S_AL_RD;
            end
          end
        end
        S_MK_RD: begin
          state <= S_MK_WR;
        end
        S_MK_WR: begin
          if (w == mk_end[6 +: WAW]) begin
            tally      <= tally - cnt;
            res_run    <= base_addr + (ADDR_W'(run_first) << PBW);
            res_status <= ST_OK;
            state      <= S_DONE;
          end else begin
            w     <= w + WAW'(1);
            state <= S_MK_RD;
          end
        end
        S_FR_PG: begin
          if (fr_end) begin
            dirty      <= 1'b0;
            tally      <= tally + freed;
            res_status <= (rejected != '0) ? ST_REJECTED : ST_OK;
            state      <= S_DONE;
          end else if (!fr_ok) begin
            rejected <= rejected + CNT_W'(1);
            fi       <= fi + CNT_W'(1);
            pa       <= pa + ADDR_W'(PAGE_BYTES);
          end else if (fr_hit) begin
            if (cd[fr_b]) begin
              cd[fr_b] <= 1'b0;
              dirty    <= 1'b1;
              freed    <= freed + CNT_W'(1);
            end else begin
              rejected <= rejected + CNT_W'(1);
            end
            fi <= fi + CNT_W'(1);
            pa <= pa + ADDR_W'(PAGE_BYTES);
          end else begin
            cw    <= fr_w;
            dirty <= 1'b0;
            state <= S_FR_LD;
          end
        end
        S_FR_LD: begin
          cd    <= mem_rdata;
          cv    <= 1'b1;
          state <= S_FR_PG;
        end
        S_DONE: begin
          if (!out_valid || out_ch.ready) begin
            out_valid  <= 1'b1;
            out_status <= res_status;
            out_run    <= res_run;
            out_freed  <= freed;
            out_rej    <= rejected;
            out_total  <= tally;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> !in_ch.ready)
    else $error("command taken while previous one in flight");

  a_mark_rmw: assert property (@(posedge clk) disable iff (rst)
    (state == S_MK_WR) |-> ($past(mem_re) && $past(mem_raddr) == mem_waddr))
    else $error("mark write-back to a word not just read");

  a_tally_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && !rc_pend) |-> (NW'(tally) <= n_pages))
    else $error("free tally exceeds pool size");

  a_free_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_FR_PG) |-> (({1'b0, freed} + {1'b0, rejected}) == {1'b0, fi}))
    else $error("freed and rejected pages do not add up");

endmodule
